// ===== sv/hsse_pkg.sv =====
package hsse_pkg;

    // Period history.
    localparam int HISTORY_DEPTH = 8;
    localparam int PERIOD_WIDTH  = 32;
    localparam int HEAD_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int COUNT_W       = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W         = PERIOD_WIDTH + HEAD_W;

    // Register file.
    localparam int REG_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RPM_SCALE       = 2'd2;
    localparam logic [REG_W-1:0] SPEED_GAIN_RST      = 32'd65536;
    localparam logic [REG_W-1:0] ANGLE_STEP_GAIN_RST = 32'd65536;
    localparam logic [REG_W-1:0] RPM_SCALE_RST       = 32'd625899;

    // Divider and scaling.
    localparam int NUM_W     = COUNT_W + REG_W;
    localparam int DIV_STEPS = NUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int MAG_W     = 31;
    localparam int PROD_W    = MAG_W + REG_W;
    localparam int FRAC_W    = 16;
    localparam logic [MAG_W-1:0] MAG_MAX = 31'h7FFF_FFFF;

    // Queue between the front and back halves.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] SECTOR_NONE = 3'd6;
    localparam logic [2:0] SECTOR_LAST = 3'd5;

    typedef enum logic [1:0] {
        MOVE_SAME  = 2'd0,
        MOVE_FWD   = 2'd1,
        MOVE_BACK  = 2'd2,
        MOVE_WRONG = 2'd3
    } move_t;

    typedef enum logic [1:0] {
        DIR_FWD  = 2'd0,
        DIR_REV  = 2'd1,
        DIR_HELD = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_DIVIDE = 2'd1,
        BK_SCALE  = 2'd2,
        BK_FINISH = 2'd3
    } back_state_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  hall_bits;
        logic [31:0] edge_period;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         sector;
        logic [1:0]         move_class;
        logic [1:0]         wrong_count;
        logic               speed_valid;
        logic signed [31:0] omega;
        logic signed [31:0] rpm;
        logic signed [31:0] angle_step;
    } out_item_t;

    typedef struct packed {
        logic               stop;
        logic [2:0]         sector;
        move_t              move_class;
        logic [1:0]         wrong_count;
        dir_t               dir;
        logic [COUNT_W-1:0] ring_count;
        logic [SUM_W-1:0]   period_sum;
    } job_t;

    function automatic logic [2:0] sector_of_code(input logic [2:0] code);
        logic [2:0] s;
        unique case (code)
            3'd1:    s = 3'd4;
            3'd2:    s = 3'd2;
            3'd3:    s = 3'd3;
            3'd4:    s = 3'd0;
            3'd5:    s = 3'd5;
            3'd6:    s = 3'd1;
            default: s = SECTOR_NONE;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] signed_word(input logic [MAG_W-1:0] mag,
                                                input logic neg);
        logic [31:0] w;
        w = {1'b0, mag};
        return neg ? (32'd0 - w) : w;
    endfunction

endpackage

// ===== sv/hsse_front.sv =====
module hsse_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  hsse_pkg::in_item_t s_data,
    output logic              job_valid,
    input  logic              job_ready,
    output hsse_pkg::job_t    job
);

    logic [2:0]                   prev_sector_reg, prev_sector_next;
    logic [1:0]                   wrong_reg, wrong_next;
    logic [hsse_pkg::HEAD_W-1:0]  head_reg, head_next;
    logic [hsse_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [hsse_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [hsse_pkg::PERIOD_WIDTH-1:0] ring_reg [hsse_pkg::HISTORY_DEPTH];

    logic                   accept;
    logic [2:0]             sector_dec;
    logic [2:0]             fwd_sector;
    logic [2:0]             back_sector;
    logic                   both_ok;
    hsse_pkg::move_t        move;
    hsse_pkg::dir_t         dir;
    logic                   push;
    logic                   full;
    logic [hsse_pkg::PERIOD_WIDTH-1:0] period;
    logic [hsse_pkg::SUM_W-1:0] drop;

    assign s_ready   = job_ready;
    assign job_valid = s_valid;
    assign accept    = s_valid && job_ready;

    assign period      = s_data.edge_period[hsse_pkg::PERIOD_WIDTH-1:0];
    assign sector_dec  = hsse_pkg::sector_of_code(s_data.hall_bits);
    assign fwd_sector  = (prev_sector_reg == hsse_pkg::SECTOR_LAST) ? 3'd0
                                                                     : prev_sector_reg + 3'd1;
    assign back_sector = (prev_sector_reg == 3'd0) ? hsse_pkg::SECTOR_LAST
                                                   : prev_sector_reg - 3'd1;
    assign both_ok     = (sector_dec != hsse_pkg::SECTOR_NONE) &&
                         (prev_sector_reg != hsse_pkg::SECTOR_NONE);

    always_comb begin
        priority if (both_ok && sector_dec == prev_sector_reg) begin
            move = hsse_pkg::MOVE_SAME;
            dir  = hsse_pkg::DIR_HELD;
        end else if (both_ok && sector_dec == fwd_sector) begin
            move = hsse_pkg::MOVE_FWD;
            dir  = hsse_pkg::DIR_FWD;
        end else if (both_ok && sector_dec == back_sector) begin
            move = hsse_pkg::MOVE_BACK;
            dir  = hsse_pkg::DIR_REV;
        end else begin
            move = hsse_pkg::MOVE_WRONG;
            dir  = hsse_pkg::DIR_FWD;
        end
    end

    assign push = !s_data.kind &&
                  (move == hsse_pkg::MOVE_FWD || move == hsse_pkg::MOVE_BACK);
    assign full = (count_reg == hsse_pkg::COUNT_W'(hsse_pkg::HISTORY_DEPTH));
    // Once the ring is full, the slot at the head holds the oldest period.
    assign drop = full ? hsse_pkg::SUM_W'(ring_reg[head_reg]) : '0;

    always_comb begin
        prev_sector_next = prev_sector_reg;
        wrong_next       = wrong_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        sum_next         = sum_reg;
        if (s_data.kind) begin
            head_next  = '0;
            count_next = '0;
            sum_next   = '0;
        end else begin
            prev_sector_next = sector_dec;
            if (move == hsse_pkg::MOVE_WRONG) begin
                if (wrong_reg != 2'd3) begin
                    wrong_next = wrong_reg + 2'd1;
                end
            end else if (push) begin
                wrong_next = 2'd0;
            end
            if (push) begin
                sum_next   = sum_reg - drop + hsse_pkg::SUM_W'(period);
                count_next = full ? count_reg : count_reg + 1'b1;
                head_next  = (head_reg == hsse_pkg::HEAD_W'(hsse_pkg::HISTORY_DEPTH - 1))
                             ? '0 : head_reg + 1'b1;
            end
        end
    end

    always_comb begin
        job.stop        = s_data.kind;
        job.sector      = s_data.kind ? prev_sector_reg : sector_dec;
        job.move_class  = s_data.kind ? hsse_pkg::MOVE_SAME : move;
        job.wrong_count = wrong_next;
        job.dir         = dir;
        job.ring_count  = count_next;
        job.period_sum  = sum_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_sector_reg <= hsse_pkg::SECTOR_NONE;
            wrong_reg       <= '0;
            head_reg        <= '0;
            count_reg       <= '0;
            sum_reg         <= '0;
        end else if (accept) begin
            prev_sector_reg <= prev_sector_next;
            wrong_reg       <= wrong_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
            sum_reg         <= sum_next;
        end
    end

    // Slots are only read back after being written since the last clear.
    always_ff @(posedge aclk) begin
        if (accept && push) begin
            ring_reg[head_reg] <= period;
        end
    end

endmodule

// ===== sv/hsse_queue.sv =====
module hsse_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  hsse_pkg::job_t in_job,
    output logic           out_valid,
    input  logic           out_ready,
    output hsse_pkg::job_t out_job
);

    hsse_pkg::job_t              slot_reg [hsse_pkg::QUEUE_DEPTH];
    logic [hsse_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [hsse_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [hsse_pkg::QCNT_W-1:0] fill_reg, fill_next;
    logic                        wr_en;
    logic                        rd_en;

    assign in_ready  = (fill_reg != hsse_pkg::QCNT_W'(hsse_pkg::QUEUE_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_job   = slot_reg[rd_ptr_reg];
    assign wr_en     = in_valid && in_ready;
    assign rd_en     = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == hsse_pkg::QPTR_W'(hsse_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == hsse_pkg::QPTR_W'(hsse_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en) begin
            fill_next = fill_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

// ===== sv/hsse_back.sv =====
module hsse_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [hsse_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hsse_pkg::REG_W-1:0]       cfg_wdata,
    input  logic                             q_valid,
    output logic                             q_ready,
    input  hsse_pkg::job_t                   q_job,
    output logic                             m_valid,
    input  logic                             m_ready,
    output hsse_pkg::out_item_t              m_data
);

    hsse_pkg::back_state_t state_reg, state_next;

    logic [hsse_pkg::REG_W-1:0] speed_gain_reg;
    logic [hsse_pkg::REG_W-1:0] angle_gain_reg;
    logic [hsse_pkg::REG_W-1:0] rpm_scale_reg;

    hsse_pkg::job_t              job_reg;
    logic [hsse_pkg::NUM_W-1:0]  num_om_reg, num_om_next;
    logic [hsse_pkg::NUM_W-1:0]  num_am_reg, num_am_next;
    logic [hsse_pkg::SUM_W-1:0]  rem_om_reg, rem_om_next;
    logic [hsse_pkg::SUM_W-1:0]  rem_am_reg, rem_am_next;
    logic [hsse_pkg::STEP_W-1:0] step_cnt_reg;
    logic [hsse_pkg::PROD_W-1:0] prod_reg;

    logic [31:0] omega_hold_reg, omega_hold_next;
    logic [31:0] rpm_hold_reg, rpm_hold_next;
    logic [31:0] angle_hold_reg, angle_hold_next;

    logic                out_valid_reg;
    hsse_pkg::out_item_t out_data_reg, out_data_next;

    logic pop;
    logic dividing;
    logic scaling;
    logic finish_fire;
    logic no_divide;

    logic [hsse_pkg::MAG_W-1:0]              om_sat;
    logic [hsse_pkg::MAG_W-1:0]              am_sat;
    logic [hsse_pkg::MAG_W-1:0]              rm_sat;
    logic [hsse_pkg::PROD_W-hsse_pkg::FRAC_W-1:0] rm_wide;
    logic                                    reverse;
    logic                                    calc_valid;

    assign no_divide = q_job.stop || (q_job.period_sum == '0);

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hsse_pkg::BK_IDLE: begin
                if (q_valid) begin
                    state_next = no_divide ? hsse_pkg::BK_FINISH : hsse_pkg::BK_DIVIDE;
                end
            end
            hsse_pkg::BK_DIVIDE: begin
                if (step_cnt_reg == '0) begin
                    state_next = hsse_pkg::BK_SCALE;
                end
            end
            hsse_pkg::BK_SCALE: begin
                state_next = hsse_pkg::BK_FINISH;
            end
            hsse_pkg::BK_FINISH: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = hsse_pkg::BK_IDLE;
                end
            end
            default: state_next = hsse_pkg::BK_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        pop         = 1'b0;
        dividing    = 1'b0;
        scaling     = 1'b0;
        finish_fire = 1'b0;
        unique case (state_reg)
            hsse_pkg::BK_IDLE:   pop         = q_valid;
            hsse_pkg::BK_DIVIDE: dividing    = 1'b1;
            hsse_pkg::BK_SCALE:  scaling     = 1'b1;
            hsse_pkg::BK_FINISH: finish_fire = !out_valid_reg || m_ready;
            default: ;
        endcase
    end

    assign q_ready = pop;

    // One restoring division step for both quotients; the numerator shifts
    // out at the top while quotient bits shift in at the bottom.
    always_comb begin
        logic [hsse_pkg::SUM_W:0] trial_om;
        logic [hsse_pkg::SUM_W:0] trial_am;
        logic [hsse_pkg::SUM_W:0] divisor;
        logic                     ge_om;
        logic                     ge_am;
        divisor  = {1'b0, job_reg.period_sum};
        trial_om = {rem_om_reg, num_om_reg[hsse_pkg::NUM_W-1]};
        trial_am = {rem_am_reg, num_am_reg[hsse_pkg::NUM_W-1]};
        ge_om    = (trial_om >= divisor);
        ge_am    = (trial_am >= divisor);
        rem_om_next = ge_om ? hsse_pkg::SUM_W'(trial_om - divisor)
                            : trial_om[hsse_pkg::SUM_W-1:0];
        rem_am_next = ge_am ? hsse_pkg::SUM_W'(trial_am - divisor)
                            : trial_am[hsse_pkg::SUM_W-1:0];
        num_om_next = {num_om_reg[hsse_pkg::NUM_W-2:0], ge_om};
        num_am_next = {num_am_reg[hsse_pkg::NUM_W-2:0], ge_am};
    end

    assign om_sat = (num_om_reg > hsse_pkg::NUM_W'(hsse_pkg::MAG_MAX))
                    ? hsse_pkg::MAG_MAX : num_om_reg[hsse_pkg::MAG_W-1:0];
    assign am_sat = (num_am_reg > hsse_pkg::NUM_W'(hsse_pkg::MAG_MAX))
                    ? hsse_pkg::MAG_MAX : num_am_reg[hsse_pkg::MAG_W-1:0];
    assign rm_wide = prod_reg[hsse_pkg::PROD_W-1:hsse_pkg::FRAC_W];
    assign rm_sat  = (rm_wide > (hsse_pkg::PROD_W - hsse_pkg::FRAC_W)'(hsse_pkg::MAG_MAX))
                     ? hsse_pkg::MAG_MAX : rm_wide[hsse_pkg::MAG_W-1:0];

    // A same-sector move keeps the direction of the speed shown last.
    always_comb begin
        unique case (job_reg.dir)
            hsse_pkg::DIR_REV:  reverse = 1'b1;
            hsse_pkg::DIR_HELD: reverse = omega_hold_reg[31];
            default:            reverse = 1'b0;
        endcase
    end

    assign calc_valid = !job_reg.stop && (job_reg.period_sum != '0);

    always_comb begin
        omega_hold_next = omega_hold_reg;
        rpm_hold_next   = rpm_hold_reg;
        angle_hold_next = angle_hold_reg;
        if (job_reg.stop) begin
            omega_hold_next = '0;
            rpm_hold_next   = '0;
        end else if (calc_valid) begin
            omega_hold_next = hsse_pkg::signed_word(om_sat, reverse);
            rpm_hold_next   = hsse_pkg::signed_word(rm_sat, reverse);
            angle_hold_next = hsse_pkg::signed_word(am_sat,
                                                    reverse && (num_om_reg != '0));
        end
        out_data_next.sector      = job_reg.sector;
        out_data_next.move_class  = job_reg.move_class;
        out_data_next.wrong_count = job_reg.wrong_count;
        out_data_next.speed_valid = calc_valid;
        out_data_next.omega       = omega_hold_next;
        out_data_next.rpm         = rpm_hold_next;
        out_data_next.angle_step  = angle_hold_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= hsse_pkg::BK_IDLE;
            out_valid_reg  <= 1'b0;
            speed_gain_reg <= hsse_pkg::SPEED_GAIN_RST;
            angle_gain_reg <= hsse_pkg::ANGLE_STEP_GAIN_RST;
            rpm_scale_reg  <= hsse_pkg::RPM_SCALE_RST;
            omega_hold_reg <= '0;
            rpm_hold_reg   <= '0;
            angle_hold_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (finish_fire) begin
                out_valid_reg  <= 1'b1;
                omega_hold_reg <= omega_hold_next;
                rpm_hold_reg   <= rpm_hold_next;
                angle_hold_reg <= angle_hold_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    hsse_pkg::REG_SPEED_GAIN:      speed_gain_reg <= cfg_wdata;
                    hsse_pkg::REG_ANGLE_STEP_GAIN: angle_gain_reg <= cfg_wdata;
                    hsse_pkg::REG_RPM_SCALE:       rpm_scale_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg      <= q_job;
            num_om_reg   <= hsse_pkg::NUM_W'(q_job.ring_count) *
                            hsse_pkg::NUM_W'(speed_gain_reg);
            num_am_reg   <= hsse_pkg::NUM_W'(q_job.ring_count) *
                            hsse_pkg::NUM_W'(angle_gain_reg);
            rem_om_reg   <= '0;
            rem_am_reg   <= '0;
            step_cnt_reg <= hsse_pkg::STEP_W'(hsse_pkg::DIV_STEPS - 1);
        end else if (dividing) begin
            num_om_reg   <= num_om_next;
            num_am_reg   <= num_am_next;
            rem_om_reg   <= rem_om_next;
            rem_am_reg   <= rem_am_next;
            step_cnt_reg <= step_cnt_reg - 1'b1;
        end
        if (scaling) begin
            prod_reg <= hsse_pkg::PROD_W'(om_sat) * hsse_pkg::PROD_W'(rpm_scale_reg);
        end
        if (finish_fire) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== sv/hall_sector_speed_estimator_core.sv =====
// Hall sector speed estimator.
// Input channel (s_valid/s_ready/s_data): one word per Hall edge or stop event.
// Result channel (m_valid/m_ready/m_data): exactly one word per input word, in order.
// Configuration: a write on cfg_we loads register cfg_index (0 speed gain,
// 1 angle step gain, 2 rpm scale); index 3 is ignored. Write only while idle.
// The front half decodes and classifies each word in the cycle it is accepted and
// updates the period ring and its running sum. A two-word queue hands the work to
// the back half, which runs two 36-step radix-2 dividers side by side, one
// multiply for rpm, and a final state that loads the output register.
// A stop event or an empty period sum skips the division and the multiply.
// The back half takes a new word from the queue only when it is idle, so it works
// on one word at a time.
// When m_ready is low the finished word waits in the output register, the back half
// waits behind it and the queue keeps taking words until it holds two.
// Synchronous reset (aresetn low) restores the register defaults, marks the
// previous sector invalid, empties the ring and the queue and clears held speeds.
module hall_sector_speed_estimator_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  hsse_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output hsse_pkg::out_item_t             m_data,
    input  logic                            cfg_we,
    input  logic [hsse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hsse_pkg::REG_W-1:0]      cfg_wdata
);

    logic           push_valid;
    logic           push_ready;
    hsse_pkg::job_t push_job;
    logic           pop_valid;
    logic           pop_ready;
    hsse_pkg::job_t pop_job;

    hsse_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job       (push_job)
    );

    hsse_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_job    (push_job),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_job   (pop_job)
    );

    hsse_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_valid   (pop_valid),
        .q_ready   (pop_ready),
        .q_job     (pop_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
